// File: rtl/fwld_pkg.sv
// Shared types and constants for the field window level detector.
// Holds the sample and result word layouts and the result kind codes.
// No dependencies.
package fwld_pkg;

    // sample and level widths
    localparam int MV_W   = 12;
    localparam int BAND_W = 13;

    // default sizing
    localparam int CAL_WINDOWS_DEF        = 12;
    localparam int MAX_WINDOW_SAMPLES_DEF = 4096;

    // deadband offset added after scaling the largest excess
    localparam int BAND_OFFSET = 5;

    // opcodes
    localparam logic OP_MEASURE   = 1'b0;
    localparam logic OP_CALIBRATE = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_MEAS      = 2'd0;
    localparam logic [1:0] KIND_CAL_STORED = 2'd1;
    localparam logic [1:0] KIND_CAL_DONE  = 2'd2;

    // input word
    typedef struct packed {
        logic              opcode;
        logic [MV_W-1:0]   sample_mv;
        logic              window_last;
    } sample_t;

    // output word
    typedef struct packed {
        logic [1:0]        kind;
        logic [MV_W-1:0]   field_level;
        logic [MV_W-1:0]   window_mean;
        logic [MV_W-1:0]   window_swing;
        logic [MV_W-1:0]   peak_level;
        logic [MV_W-1:0]   base_mean_out;
        logic [MV_W-1:0]   base_swing_out;
        logic [BAND_W-1:0] dead_band_out;
    } result_t;

endpackage

// File: rtl/field_window_level_detector_core.sv
// Field window level detector: window statistics, level, peak and calibration.
// Top level; one module with the calibration store and a serial mean divider.
// Depends on fwld_pkg.
//
// Usage
//   Input channel (sample_valid / sample_stall / sample) carries one ADC word per
//   handshake; window_last closes a window, and opcode on that word selects a
//   measurement or a calibration window. Output channel (result_valid /
//   result_stall / result) carries one word per closed window.
//   A word without window_last is taken and only updates the accumulators. A
//   closing word runs the mean through a restoring divider, one quotient bit
//   per cycle. A measurement window then passes ST_LVL1 and ST_LVL2, and a
//   stored calibration window ST_CWR, before ST_OUT loads the output register
//   and result_valid rises. The closing calibration window adds two walks over
//   the calibration memory (ST_CSUM, ST_CMAX) and two reciprocal multiplies
//   (ST_CDIVM, ST_CDIVS), then sets the deadband in ST_CBAND.
//   sample_stall is high from a window end until its word enters the output
//   register; while the receiver stalls, that window end holds the input.
//   Reset clears accumulators, baselines, deadband and peak, not the memory.
module field_window_level_detector_core #(
    parameter int CAL_WINDOWS        = fwld_pkg::CAL_WINDOWS_DEF,
    parameter int MAX_WINDOW_SAMPLES = fwld_pkg::MAX_WINDOW_SAMPLES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  fwld_pkg::sample_t sample,
    output logic              result_valid,
    input  logic              result_stall,
    output fwld_pkg::result_t result
);
    import fwld_pkg::*;

    // derived sizes
    localparam int CNT_W   = $clog2(MAX_WINDOW_SAMPLES + 1);
    localparam int SUM_W   = CNT_W + MV_W;
    localparam int IDX_W   = (CAL_WINDOWS > 1) ? $clog2(CAL_WINDOWS) : 1;
    localparam int STEP_W  = $clog2(CAL_WINDOWS + 1);
    localparam int CSUM_W  = MV_W + STEP_W;
    localparam int DIV_W   = SUM_W;
    localparam int DVS_W   = CNT_W;
    localparam int DCNT_W  = $clog2(DIV_W);
    localparam int EXC_W   = MV_W + 1;
    localparam int NET_W   = EXC_W + 2;

    // reciprocal for the division of the calibration sums by CAL_WINDOWS
    localparam int CDIV_SH = CSUM_W + $clog2(CAL_WINDOWS);
    localparam int CDIV_MW = CSUM_W + 1;
    localparam int CDIV_M  = ((1 << CDIV_SH) + CAL_WINDOWS - 1) / CAL_WINDOWS;
    localparam int PROD_W  = CSUM_W + CDIV_MW;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WDIV,
        ST_LVL1,
        ST_LVL2,
        ST_CWR,
        ST_CSUM,
        ST_CDIVM,
        ST_CDIVS,
        ST_CMAX,
        ST_CBAND,
        ST_OUT
    } state_t;

    state_t                    state_reg;

    // window accumulators
    logic [SUM_W-1:0]          win_sum_reg;
    logic [CNT_W-1:0]          win_count_reg;
    logic [MV_W-1:0]           win_min_reg;
    logic [MV_W-1:0]           win_max_reg;

    // calibration and level state
    logic [IDX_W-1:0]          cal_index_reg;
    logic [MV_W-1:0]           base_mean_reg;
    logic [MV_W-1:0]           base_swing_reg;
    logic [BAND_W-1:0]         dead_band_reg;
    logic [MV_W-1:0]           peak_reg;

    // per-window working registers
    logic                      op_reg;
    logic [MV_W-1:0]           mean_reg;
    logic [MV_W-1:0]           swing_reg;
    logic [MV_W-1:0]           level_reg;
    logic [1:0]                kind_reg;
    logic signed [EXC_W-1:0]   exc_reg;

    // calibration walk
    logic [STEP_W-1:0]         step_reg;
    logic [CSUM_W-1:0]         msum_reg;
    logic [CSUM_W-1:0]         ssum_reg;
    logic [MV_W-1:0]           band_reg;

    // serial divider
    logic [DIV_W-1:0]          div_quo_reg;
    logic [DVS_W-1:0]          div_rem_reg;
    logic [DVS_W-1:0]          div_dvs_reg;
    logic [DCNT_W-1:0]         div_cnt_reg;

    // output register
    logic                      result_valid_reg;
    result_t                   result_reg;

    // calibration memory: {mean, swing} per window
    logic [2*MV_W-1:0]         cal_mem [CAL_WINDOWS];
    logic [2*MV_W-1:0]         rd_data_reg;
    logic [IDX_W-1:0]          mem_raddr;
    logic                      mem_we;

    // ------------------------------------------------------------------
    // Accumulator update for the incoming word
    logic                      smp_take;
    logic                      in_fire;
    logic [SUM_W-1:0]          sum_upd;
    logic [CNT_W-1:0]          cnt_upd;
    logic [MV_W-1:0]           min_upd;
    logic [MV_W-1:0]           max_upd;
    logic [MV_W-1:0]           swing_upd;

    assign in_fire  = sample_valid && !sample_stall;
    assign smp_take = (win_count_reg < CNT_W'(MAX_WINDOW_SAMPLES));

    always_comb
    begin
        sum_upd = win_sum_reg;
        cnt_upd = win_count_reg;
        min_upd = win_min_reg;
        max_upd = win_max_reg;
        if (smp_take)
        begin
            sum_upd = win_sum_reg + SUM_W'(sample.sample_mv);
            cnt_upd = win_count_reg + CNT_W'(1);
            if (sample.sample_mv < win_min_reg)
                min_upd = sample.sample_mv;
            if (sample.sample_mv > win_max_reg)
                max_upd = sample.sample_mv;
        end
        swing_upd = (max_upd >= min_upd) ? (max_upd - min_upd) : '0;
    end

    // ------------------------------------------------------------------
    // Divider step: one quotient bit per cycle
    logic [DVS_W:0]            div_rem_sh;
    logic                      div_ge;
    logic [DVS_W-1:0]          div_rem_next;
    logic [DIV_W-1:0]          div_quo_next;
    logic                      div_done;
    logic [MV_W-1:0]           div_result;

    always_comb
    begin
        div_rem_sh   = {div_rem_reg, div_quo_reg[DIV_W-1]};
        div_ge       = (div_rem_sh >= {1'b0, div_dvs_reg});
        div_rem_next = div_ge ? DVS_W'(div_rem_sh - {1'b0, div_dvs_reg})
                              : div_rem_sh[DVS_W-1:0];
        div_quo_next = {div_quo_reg[DIV_W-2:0], div_ge};
        div_done     = (div_cnt_reg == DCNT_W'(DIV_W - 1));
        div_result   = div_quo_next[MV_W-1:0];
    end

    // ------------------------------------------------------------------
    // Measurement level arithmetic
    logic signed [EXC_W-1:0]   lvl_dm;
    logic signed [EXC_W-1:0]   lvl_dp;
    logic signed [NET_W-1:0]   lvl_net;
    logic [MV_W-1:0]           lvl_level;

    always_comb
    begin
        lvl_dm  = $signed({1'b0, mean_reg})  - $signed({1'b0, base_mean_reg});
        lvl_dp  = $signed({1'b0, swing_reg}) - $signed({1'b0, base_swing_reg});
        lvl_net = $signed({{2{exc_reg[EXC_W-1]}}, exc_reg})
                - $signed({2'b00, dead_band_reg});
        if (lvl_net < 0)
            lvl_level = '0;
        else if (lvl_net > $signed(NET_W'(2**MV_W - 1)))
            lvl_level = '1;
        else
            lvl_level = lvl_net[MV_W-1:0];
    end

    // ------------------------------------------------------------------
    // Calibration walk arithmetic on the word read from memory
    logic [MV_W-1:0]           rd_mean;
    logic [MV_W-1:0]           rd_swing;
    logic [CSUM_W-1:0]         msum_add;
    logic [CSUM_W-1:0]         ssum_add;
    logic signed [EXC_W-1:0]   cal_dm;
    logic signed [EXC_W-1:0]   cal_dp;
    logic signed [EXC_W-1:0]   cal_d;
    logic                      step_last;
    logic [BAND_W-1:0]         band_scaled;
    logic [CSUM_W-1:0]         cdiv_in;
    logic [PROD_W-1:0]         cdiv_prod;
    logic [MV_W-1:0]           cdiv_quo;

    always_comb
    begin
        rd_mean     = rd_data_reg[2*MV_W-1:MV_W];
        rd_swing    = rd_data_reg[MV_W-1:0];
        msum_add    = msum_reg + CSUM_W'(rd_mean);
        ssum_add    = ssum_reg + CSUM_W'(rd_swing);
        cal_dm      = $signed({1'b0, rd_mean})  - $signed({1'b0, base_mean_reg});
        cal_dp      = $signed({1'b0, rd_swing}) - $signed({1'b0, base_swing_reg});
        cal_d       = (cal_dm > cal_dp) ? cal_dm : cal_dp;
        step_last   = (step_reg == STEP_W'(CAL_WINDOWS));
        band_scaled = BAND_W'(band_reg) + BAND_W'(band_reg >> 1)
                    + BAND_W'(BAND_OFFSET);
        mem_raddr   = (step_reg < STEP_W'(CAL_WINDOWS)) ? step_reg[IDX_W-1:0] : '0;
        mem_we      = (state_reg == ST_CWR);
        // sum / CAL_WINDOWS, exact for every sum that fits CSUM_W bits
        cdiv_in     = (state_reg == ST_CDIVS) ? ssum_reg : msum_reg;
        cdiv_prod   = PROD_W'(cdiv_in) * PROD_W'(CDIV_M);
        cdiv_quo    = cdiv_prod[CDIV_SH +: MV_W];
    end

    // ------------------------------------------------------------------
    // Calibration memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            cal_mem[cal_index_reg] <= {mean_reg, swing_reg};
        rd_data_reg <= cal_mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // Sequencer, accumulators and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            win_sum_reg      <= '0;
            win_count_reg    <= '0;
            win_min_reg      <= '1;
            win_max_reg      <= '0;
            cal_index_reg    <= '0;
            base_mean_reg    <= '0;
            base_swing_reg   <= '0;
            dead_band_reg    <= '0;
            peak_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // output word taken; ST_OUT refills the register itself
            if (result_valid_reg && !result_stall && (state_reg != ST_OUT))
                result_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (sample.window_last)
                        begin
                            op_reg        <= sample.opcode;
                            swing_reg     <= swing_upd;
                            div_quo_reg   <= DIV_W'(sum_upd);
                            div_rem_reg   <= '0;
                            div_dvs_reg   <= DVS_W'(cnt_upd);
                            div_cnt_reg   <= '0;
                            win_sum_reg   <= '0;
                            win_count_reg <= '0;
                            win_min_reg   <= '1;
                            win_max_reg   <= '0;
                            state_reg     <= ST_WDIV;
                        end
                        else
                        begin
                            win_sum_reg   <= sum_upd;
                            win_count_reg <= cnt_upd;
                            win_min_reg   <= min_upd;
                            win_max_reg   <= max_upd;
                        end
                    end
                end

                // window mean
                ST_WDIV:
                begin
                    div_quo_reg <= div_quo_next;
                    div_rem_reg <= div_rem_next;
                    div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
                    if (div_done)
                    begin
                        mean_reg  <= div_result;
                        state_reg <= (op_reg == OP_CALIBRATE) ? ST_CWR : ST_LVL1;
                    end
                end

                // larger excess over the baselines
                ST_LVL1:
                begin
                    exc_reg   <= (lvl_dm > lvl_dp) ? lvl_dm : lvl_dp;
                    state_reg <= ST_LVL2;
                end

                // net level, peak, abandon partial calibration
                ST_LVL2:
                begin
                    level_reg     <= lvl_level;
                    if (lvl_level > peak_reg)
                        peak_reg  <= lvl_level;
                    cal_index_reg <= '0;
                    kind_reg      <= KIND_MEAS;
                    state_reg     <= ST_OUT;
                end

                // store one calibration window (memory write in this state)
                ST_CWR:
                begin
                    level_reg <= '0;
                    if (cal_index_reg == IDX_W'(CAL_WINDOWS - 1))
                    begin
                        cal_index_reg <= '0;
                        step_reg      <= '0;
                        msum_reg      <= '0;
                        ssum_reg      <= '0;
                        state_reg     <= ST_CSUM;
                    end
                    else
                    begin
                        cal_index_reg <= cal_index_reg + IDX_W'(1);
                        kind_reg      <= KIND_CAL_STORED;
                        state_reg     <= ST_OUT;
                    end
                end

                // sum the stored means and swings
                ST_CSUM:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg != '0)
                    begin
                        msum_reg <= msum_add;
                        ssum_reg <= ssum_add;
                    end
                    if (step_last)
                        state_reg <= ST_CDIVM;
                end

                // baseline mean
                ST_CDIVM:
                begin
                    base_mean_reg <= cdiv_quo;
                    state_reg     <= ST_CDIVS;
                end

                // baseline swing
                ST_CDIVS:
                begin
                    base_swing_reg <= cdiv_quo;
                    step_reg       <= '0;
                    band_reg       <= '0;
                    state_reg      <= ST_CMAX;
                end

                // largest excess over the new baselines
                ST_CMAX:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if ((step_reg != '0) && (cal_d > $signed({1'b0, band_reg})))
                        band_reg <= cal_d[MV_W-1:0];
                    if (step_last)
                        state_reg <= ST_CBAND;
                end

                ST_CBAND:
                begin
                    dead_band_reg <= band_scaled;
                    peak_reg      <= '0;
                    kind_reg      <= KIND_CAL_DONE;
                    state_reg     <= ST_OUT;
                end

                // hand the word to the output register once it is free
                ST_OUT:
                begin
                    if (!result_valid_reg || !result_stall)
                    begin
                        result_reg.kind           <= kind_reg;
                        result_reg.field_level    <= level_reg;
                        result_reg.window_mean    <= mean_reg;
                        result_reg.window_swing   <= swing_reg;
                        result_reg.peak_level     <= peak_reg;
                        result_reg.base_mean_out  <= base_mean_reg;
                        result_reg.base_swing_out <= base_swing_reg;
                        result_reg.dead_band_out  <= dead_band_reg;
                        result_valid_reg          <= 1'b1;
                        state_reg                 <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Checks
    a_cal_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        cal_index_reg <= IDX_W'(CAL_WINDOWS - 1))
        else $error("calibration index past last entry");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        win_count_reg <= CNT_W'(MAX_WINDOW_SAMPLES))
        else $error("window count past its limit");

    a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && sample.window_last |=> sample_stall)
        else $error("window end did not stall the input");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_reg.kind == KIND_MEAS ||
                              result_reg.kind == KIND_CAL_STORED ||
                              result_reg.kind == KIND_CAL_DONE))
        else $error("illegal result kind");

    a_cal_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && (result_reg.kind != KIND_MEAS)
            |-> (result_reg.field_level == '0))
        else $error("nonzero level on a calibration result");

    a_cal_done_clears_peak: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) && (result_reg.kind == KIND_CAL_DONE)
            |-> (result_reg.peak_level == '0))
        else $error("peak not cleared by finished calibration");

endmodule
